// ===== rtl/core/asg_pkg.sv =====
// Package for the active search grid core: constants, op codes, FSM states.
// No dependencies.
package asg_pkg;
	localparam int MAX_CELLS = 16;
	localparam int GRID_SIDE = MAX_CELLS + 1;
	localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(GRID_CELLS);
	localparam int IDX_W = $clog2(GRID_SIDE);
	localparam int CNT_W = 9;
	localparam int KCNT_W = $clog2(GRID_CELLS + 1);
	localparam logic [CNT_W-1:0] CNT_FAILED = '1;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_RENEW = 3'd1,
		OP_ADD = 3'd2,
		OP_PICK = 3'd3,
		OP_FAIL = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_CELLS_H = 3'd0,
		REG_CELLS_V = 3'd1,
		REG_CELL_W = 3'd2,
		REG_CELL_H = 3'd3,
		REG_MARGIN = 3'd4,
		REG_SEP = 3'd5
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVX,
		ST_LOC,
		ST_RMW,
		ST_CLEAR,
		ST_CNT,
		ST_MOD,
		ST_FIND,
		ST_EDGE,
		ST_DONE
	} state_t;

	// Request to the shared serial divider.
	typedef struct packed {
		logic        start;
		logic [23:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [23:0] quot;
		logic [15:0] rem;
	} div_rsp_t;
endpackage

// ===== rtl/core/asg_div.sv =====
// Restoring divider, one quotient bit per cycle; done is a one-cycle strobe after the last bit.
// Depends on asg_pkg.
module asg_div
	import asg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [23:0] quot_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], quot_q[23]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quot_q <= {quot_q[22:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quot_q[23]};
				quot_q <= {quot_q[22:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem = rem_q[15:0];
endmodule

// ===== rtl/core/asg_mem.sv =====
// Cell count memory, one write and one registered read port.
// Depends on asg_pkg.
module asg_mem
	import asg_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CNT_W-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CNT_W-1:0]  rdata
);
	logic [CNT_W-1:0] mem [GRID_CELLS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/active_search_grid_core.sv =====
// Top level of the active search grid core: control sequencer, config regs.
// Depends on asg_pkg, asg_div, asg_mem.
//
// channel | signals                                         | handshake
// cmd     | start, operation, pixel_x/y, region_*_in, rand  | start && !busy
// result  | done, region_found, region_x/y/width/height     | one-cycle strobe
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | valid && ready
//
// One command at a time. Add and fail: two serial divisions, then one
// read-modify-write of the count memory if the point lies in the grid. Clear
// and renew: a clearing sweep of the memory (renew runs two divisions first).
// Pick: scans of the full 289-entry memory (one to count empty inner cells and,
// if there are any, one to find the chosen one) with a division between them.
// After reset a clearing pass over all 289 entries runs with busy high.
// Results cannot be stalled.
module active_search_grid_core
	import asg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	input  logic [10:0] region_w_in,
	input  logic [10:0] region_h_in,
	input  logic [15:0] random_a,
	input  logic [15:0] random_b,
	output logic        done,
	output logic        region_found,
	output logic [11:0] region_x,
	output logic [11:0] region_y,
	output logic [10:0] region_width,
	output logic [10:0] region_height,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	logic [4:0]  cells_h_q, cells_v_q;
	logic [10:0] cell_w_q, cell_h_q;
	logic [7:0]  margin_q, sep_q;
	logic [10:0] off_x_q, off_y_q;

	state_t state_q, state_d;
	logic [2:0]  op_q;
	logic [12:0] py_q;
	logic [15:0] ra_q, rb_q;
	logic        phase_q;      // second division / second scan
	logic        init_q;       // clearing pass after reset, no result
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  ci_q, cj_q;   // scan position
	logic [KCNT_W-1:0] k_q, pick_q;
	logic        rd_ok_s1;     // scan read in flight is an inner cell
	logic [IDX_W-1:0] ri_s1, rj_s1;
	logic        found_q;
	logic [IDX_W-1:0] fi_q, fj_q;
	logic [23:0] cx_q;
	logic        loc_ok_q;
	logic        res_found_q;
	logic [11:0] res_x_q, res_y_q;
	logic [10:0] res_w_q, res_h_q;
	logic        done_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CNT_W-1:0]  mem_wdata, mem_rdata;

	asg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	asg_mem u_mem (.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata));

	// Effective sizes and grid lengths.
	logic [10:0] ew, eh;
	logic [4:0]  gh, gv;
	assign ew = (cell_w_q == 11'd0) ? 11'd1 : cell_w_q;
	assign eh = (cell_h_q == 11'd0) ? 11'd1 : cell_h_q;
	assign gh = ((cells_h_q > 5'(MAX_CELLS)) ? 5'(MAX_CELLS) : cells_h_q) + 5'd1;
	assign gv = ((cells_v_q > 5'(MAX_CELLS)) ? 5'(MAX_CELLS) : cells_v_q) + 5'd1;

	logic [11:0] span_x, span_y;
	assign span_x = {1'b0, ew} - {3'b0, margin_q, 1'b0};
	assign span_y = {1'b0, eh} - {3'b0, margin_q, 1'b0};
	logic big_x, big_y;
	assign big_x = {1'b0, ew} > {3'b0, margin_q, 1'b0};
	assign big_y = {1'b0, eh} > {3'b0, margin_q, 1'b0};

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_h_q <= 5'd8;
			cells_v_q <= 5'd6;
			cell_w_q <= 11'd80;
			cell_h_q <= 11'd80;
			margin_q <= '0;
			sep_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CELLS_H: cells_h_q <= cfg_data[4:0];
				REG_CELLS_V: cells_v_q <= cfg_data[4:0];
				REG_CELL_W:  cell_w_q <= cfg_data;
				REG_CELL_H:  cell_h_q <= cfg_data;
				REG_MARGIN:  margin_q <= cfg_data[7:0];
				REG_SEP:     sep_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic last_addr, scan_end;
	assign last_addr = (addr_q == ADDR_W'(GRID_CELLS - 1));
	assign scan_end = (ci_q == IDX_W'(GRID_SIDE - 1)) && (cj_q == IDX_W'(GRID_SIDE - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (operation)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_RENEW: state_d = ST_DIVX;
						OP_ADD, OP_FAIL: state_d = ST_DIVX;
						OP_PICK: state_d = ST_CNT;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_DIVX: if (drsp.done && phase_q)
				state_d = (op_q == OP_RENEW) ? ST_CLEAR : ST_LOC;
			ST_LOC: state_d = loc_ok_q ? ST_RMW : ST_DONE;
			ST_RMW: state_d = ST_DONE;
			ST_CLEAR: if (last_addr) state_d = ST_DONE;
			ST_CNT: if (scan_end) state_d = phase_q ? ST_EDGE : ST_MOD;
			ST_MOD: begin
				if (k_q == '0) state_d = ST_DONE;
				else if (drsp.done) state_d = ST_FIND;
			end
			ST_FIND: if (scan_end) state_d = ST_EDGE;
			ST_EDGE: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Divider requests.
	logic [12:0] fx, fy;
	assign fx = {1'b0, pixel_x} + {3'b0, region_w_in[10:1]};
	assign fy = {1'b0, pixel_y} + {3'b0, region_h_in[10:1]};
	always_comb begin
		dreq = '0;
		if (state_q == ST_IDLE && start &&
		    (operation == OP_RENEW || operation == OP_ADD || operation == OP_FAIL)) begin
			dreq.start = 1'b1;
			if (operation == OP_RENEW) begin
				dreq.dividend = {8'b0, random_a};
				dreq.divisor = {4'b0, span_x};
			end else begin
				dreq.dividend = 24'(((operation == OP_FAIL) ? fx : {1'b0, pixel_x}))
					+ 24'(off_x_q);
				dreq.divisor = {5'b0, ew};
			end
		end else if (state_q == ST_DIVX && drsp.done && !phase_q) begin
			dreq.start = 1'b1;
			if (op_q == OP_RENEW) begin
				dreq.dividend = {8'b0, rb_q};
				dreq.divisor = {4'b0, span_y};
			end else begin
				dreq.dividend = 24'(py_q) + 24'(off_y_q);
				dreq.divisor = {5'b0, eh};
			end
		end else if (state_q == ST_CNT && scan_end && !phase_q) begin
			dreq.start = 1'b1;
			dreq.dividend = {8'b0, ra_q};
			dreq.divisor = 16'(k_q);
		end
	end

	// Memory access.
	logic [ADDR_W-1:0] scan_addr, loc_addr;
	assign scan_addr = ADDR_W'(ci_q * GRID_SIDE) + ADDR_W'(cj_q);
	assign loc_addr = ADDR_W'(fi_q * GRID_SIDE) + ADDR_W'(fj_q);
	logic inner;
	assign inner = (ci_q != '0) && (5'(ci_q) + 5'd1 < gh) &&
	               (cj_q != '0) && (5'(cj_q) + 5'd1 < gv);
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = addr_q;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_LOC: mem_raddr = loc_addr;	// read ahead of the RMW cycle
			ST_RMW: begin
				mem_we = 1'b1;
				if (op_q == OP_FAIL) mem_wdata = CNT_FAILED;
				else if (mem_rdata[CNT_W-1]) mem_wdata = 9'd1;
				else if (mem_rdata == 9'd255) mem_wdata = mem_rdata;
				else mem_wdata = mem_rdata + 9'd1;
			end
			ST_CNT, ST_FIND: mem_raddr = scan_addr;
			default: ;
		endcase
	end

	// Edge arithmetic.
	logic signed [19:0] ex, ey;
	logic [19:0] pwx, pwy;
	logic [11:0] shw, shh;
	assign pwx = ew * fi_q;
	assign pwy = eh * fj_q;
	assign ex = $signed(pwx) - $signed({9'b0, off_x_q}) + $signed({12'b0, sep_q});
	assign ey = $signed(pwy) - $signed({9'b0, off_y_q}) + $signed({12'b0, sep_q});
	assign shw = {1'b0, ew} - {3'b0, sep_q, 1'b0};
	assign shh = {1'b0, eh} - {3'b0, sep_q, 1'b0};

	logic hit0;
	assign hit0 = rd_ok_s1 && (mem_rdata == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			phase_q <= 1'b0;
			init_q <= 1'b1;
			done_q <= 1'b0;
			off_x_q <= '0;
			off_y_q <= '0;
			op_q <= OP_CLEAR;
			rd_ok_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_DONE) && !init_q;
			rd_ok_s1 <= (state_q == ST_CNT || state_q == ST_FIND) && inner;
			case (state_q)
				ST_IDLE: if (start) begin
					op_q <= operation;
					phase_q <= 1'b0;
					addr_q <= '0;
				end
				ST_DIVX: if (drsp.done) begin
					phase_q <= 1'b1;
					if (op_q == OP_RENEW) begin
						if (!phase_q) off_x_q <= big_x ?
							11'(margin_q) + drsp.rem[10:0] : 11'(margin_q);
						else off_y_q <= big_y ?
							11'(margin_q) + drsp.rem[10:0] : 11'(margin_q);
					end
				end
				ST_LOC: addr_q <= loc_addr;
				ST_CLEAR: addr_q <= addr_q + 1'b1;
				ST_CNT: if (scan_end) phase_q <= 1'b1;
				ST_DONE: begin
					addr_q <= '0;
					init_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				py_q <= (operation == OP_FAIL) ? fy : {1'b0, pixel_y};
				ra_q <= random_a;
				rb_q <= random_b;
				ci_q <= '0;
				cj_q <= '0;
				k_q <= '0;
				found_q <= 1'b0;
				res_found_q <= 1'b0;
				res_x_q <= '0;
				res_y_q <= '0;
				res_w_q <= '0;
				res_h_q <= '0;
			end
			ST_DIVX: if (drsp.done) begin
				if (!phase_q) begin
					cx_q <= drsp.quot;
				end else begin
					loc_ok_q <= (cx_q < 24'(gh)) && (drsp.quot < 24'(gv));
					fi_q <= cx_q[IDX_W-1:0];
					fj_q <= drsp.quot[IDX_W-1:0];
				end
			end
			ST_CNT, ST_FIND: begin
				ri_s1 <= ci_q;
				rj_s1 <= cj_q;
				if (scan_end) begin
					ci_q <= '0;
					cj_q <= '0;
				end else if (cj_q == IDX_W'(GRID_SIDE - 1)) begin
					cj_q <= '0;
					ci_q <= ci_q + 1'b1;
				end else cj_q <= cj_q + 1'b1;
				if (hit0) begin
					if (state_q == ST_CNT && !phase_q) k_q <= k_q + 1'b1;
					if (state_q == ST_FIND) begin
						if (pick_q == '0 && !found_q) begin
							fi_q <= ri_s1;
							fj_q <= rj_s1;
							found_q <= 1'b1;
						end
						pick_q <= pick_q - 1'b1;
					end
				end
			end
			ST_MOD: if (drsp.done) pick_q <= KCNT_W'(drsp.rem);
			ST_EDGE: begin
				res_found_q <= 1'b1;
				res_x_q <= ex[19] ? 12'd0 : (ex > 20'sd4095) ? 12'd4095 : ex[11:0];
				res_y_q <= ey[19] ? 12'd0 : (ey > 20'sd4095) ? 12'd4095 : ey[11:0];
				res_w_q <= shw[11] ? 11'd0 : shw[10:0];
				res_h_q <= shh[11] ? 11'd0 : shh[10:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign region_found = res_found_q & done_q;
	assign region_x = done_q ? res_x_q : '0;
	assign region_y = done_q ? res_y_q : '0;
	assign region_width = done_q ? res_w_q : '0;
	assign region_height = done_q ? res_h_q : '0;

	a_busy_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command not taken");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("double result strobe");
	a_found_only_pick: assert property (@(posedge clk) disable iff (!arst_n)
		region_found |-> (op_q == OP_PICK))
		else $error("found on non-pick");
endmodule

// ===== verif/tb_active_search_grid_core.sv =====
`timescale 1ns / 100ps
// Testbench for active_search_grid_core: directed and random commands checked
// against a behavioral grid model. Depends on asg_pkg and the core RTL.

// Queue of expected regions; notes each accepted command, checks each result.
class grid_scoreboard;
	typedef struct {
		logic        found;
		logic [11:0] rx;
		logic [11:0] ry;
		logic [10:0] rw;
		logic [10:0] rh;
	} region_t;

	// configuration and state copies
	int unsigned cfg_cells_h = 8, cfg_cells_v = 6, cfg_cw = 80, cfg_ch = 80;
	int unsigned cfg_margin = 0, cfg_sep = 0;
	int counts[asg_pkg::GRID_CELLS];
	int unsigned off_x = 0, off_y = 0;
	region_t pending_regions[$];
	int errors = 0;
	int found_count = 0;

	function void wipe_grid();
		foreach (counts[i]) counts[i] = 0;
	endfunction

	function int unsigned axis_len(int unsigned n);
		return ((n > asg_pkg::MAX_CELLS) ? asg_pkg::MAX_CELLS : n) + 1;
	endfunction

	function int unsigned nz(int unsigned s);
		return (s == 0) ? 1 : s;
	endfunction

	function int unsigned shift_draw(int unsigned size, int unsigned rnd);
		int unsigned s;
		s = nz(size);
		if (s <= 2 * cfg_margin)
			return cfg_margin;
		return cfg_margin + rnd % (s - 2 * cfg_margin);
	endfunction

	function bit cell_of(int unsigned px, int unsigned py, output int unsigned slot);
		int unsigned cx, cy;
		cx = (px + off_x) / nz(cfg_cw);
		cy = (py + off_y) / nz(cfg_ch);
		slot = 0;
		if (cx >= axis_len(cfg_cells_h) || cy >= axis_len(cfg_cells_v))
			return 0;
		slot = cx * asg_pkg::GRID_SIDE + cy;
		return 1;
	endfunction

	function int unsigned edge_pos(int unsigned size, int unsigned idx, int unsigned off);
		longint v;
		v = longint'(nz(size)) * idx - off + cfg_sep;
		if (v < 0) return 0;
		if (v > 4095) return 4095;
		return 32'(v);
	endfunction

	function int unsigned trimmed(int unsigned size);
		int unsigned s;
		s = nz(size);
		return (s > 2 * cfg_sep) ? s - 2 * cfg_sep : 0;
	endfunction

	function void write_reg(asg_pkg::reg_t idx, int unsigned val);
		case (idx)
			asg_pkg::REG_CELLS_H: cfg_cells_h = val & 'h1f;
			asg_pkg::REG_CELLS_V: cfg_cells_v = val & 'h1f;
			asg_pkg::REG_CELL_W: cfg_cw = val & 'h7ff;
			asg_pkg::REG_CELL_H: cfg_ch = val & 'h7ff;
			asg_pkg::REG_MARGIN: cfg_margin = val & 'hff;
			asg_pkg::REG_SEP: cfg_sep = val & 'hff;
			default: ;
		endcase
	endfunction

	// Apply one accepted command and queue the region it yields.
	function void note_command(logic [2:0] op, int unsigned px, int unsigned py,
			int unsigned rw, int unsigned rh, int unsigned ra, int unsigned rb);
		region_t r;
		int unsigned slot, gh, gv, k, n, sel;
		r = '{default: 0};
		case (op)
			asg_pkg::OP_CLEAR: wipe_grid();
			asg_pkg::OP_RENEW: begin
				off_x = shift_draw(cfg_cw, ra);
				off_y = shift_draw(cfg_ch, rb);
				wipe_grid();
			end
			asg_pkg::OP_ADD: begin
				if (cell_of(px, py, slot)) begin
					if (counts[slot] < 0) counts[slot] = 0;
					if (counts[slot] < 255) counts[slot]++;
				end
			end
			asg_pkg::OP_PICK: begin
				gh = axis_len(cfg_cells_h);
				gv = axis_len(cfg_cells_v);
				k = 0;
				n = 0;
				for (int i = 1; i + 1 < gh; i++)
					for (int j = 1; j + 1 < gv; j++)
						if (counts[i * asg_pkg::GRID_SIDE + j] == 0) k++;
				if (k > 0) begin
					sel = ra % k;
					for (int i = 1; i + 1 < gh; i++)
						for (int j = 1; j + 1 < gv; j++) begin
							if (counts[i * asg_pkg::GRID_SIDE + j] == 0) begin
								if (n == sel) begin
									r.found = 1;
									r.rx = 12'(edge_pos(cfg_cw, i, off_x));
									r.ry = 12'(edge_pos(cfg_ch, j, off_y));
									r.rw = 11'(trimmed(cfg_cw));
									r.rh = 11'(trimmed(cfg_ch));
								end
								n++;
							end
						end
				end
			end
			asg_pkg::OP_FAIL: begin
				if (cell_of(px + rw / 2, py + rh / 2, slot))
					counts[slot] = -1;
			end
			default: ;
		endcase
		pending_regions.push_back(r);
	endfunction

	function void check_region(logic found, logic [11:0] rx, logic [11:0] ry,
			logic [10:0] rw, logic [10:0] rh);
		region_t e;
		if (pending_regions.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual found=%0d x=%0d y=%0d",
				$time, found, rx, ry);
			errors++;
			return;
		end
		e = pending_regions.pop_front();
		if (found) found_count++;
		if (found !== e.found) begin
			$display("%0t: region_found expected %0d actual %0d", $time, e.found, found);
			errors++;
		end
		if (rx !== e.rx) begin
			$display("%0t: region_x expected %0d actual %0d", $time, e.rx, rx);
			errors++;
		end
		if (ry !== e.ry) begin
			$display("%0t: region_y expected %0d actual %0d", $time, e.ry, ry);
			errors++;
		end
		if (rw !== e.rw) begin
			$display("%0t: region_width expected %0d actual %0d", $time, e.rw, rw);
			errors++;
		end
		if (rh !== e.rh) begin
			$display("%0t: region_height expected %0d actual %0d", $time, e.rh, rh);
			errors++;
		end
	endfunction
endclass

module tb_active_search_grid_core;
	import asg_pkg::*;

	localparam int STALL_LIMIT = 20000;	// far above the run of a pick plus the gap between commands

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [2:0]  operation = OP_CLEAR;
	logic [11:0] pixel_x = 0;
	logic [11:0] pixel_y = 0;
	logic [10:0] region_w_in = 0;
	logic [10:0] region_h_in = 0;
	logic [15:0] random_a = 0;
	logic [15:0] random_b = 0;
	logic        done;
	logic        region_found;
	logic [11:0] region_x;
	logic [11:0] region_y;
	logic [10:0] region_width;
	logic [10:0] region_height;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 0;
	logic [10:0] cfg_data = 0;

	grid_scoreboard grid_sb = new();
	int idle_cycles = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	active_search_grid_core u_dut (.*);

	// Result strobe: sampled at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			grid_sb.check_region(region_found, region_x, region_y, region_width,
				region_height);
	end

	// Watchdog: count cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("active_search_grid_core test failed");
			$finish;
		end
	end

	// One command transaction after a random gap; start stays high on a zero gap.
	task automatic send_cmd(logic [2:0] op, int unsigned px, int unsigned py,
			int unsigned rw, int unsigned rh, int unsigned ra, int unsigned rb);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;	// runs with no idling
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		pixel_x <= 12'(px);
		pixel_y <= 12'(py);
		region_w_in <= 11'(rw);
		region_h_in <= 11'(rh);
		random_a <= 16'(ra);
		random_b <= 16'(rb);
		start <= 1;
		do @(posedge clk); while (busy);
		grid_sb.note_command(op, px, py, rw, rh, ra, rb);
	endtask

	// Wait for all results, then the latency of an op with no pending result.
	task automatic drain();
		start <= 0;
		while (grid_sb.pending_regions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_cfg(reg_t idx, int unsigned val);
		cfg_index <= idx;
		cfg_data <= 11'(val);
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		grid_sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic setup(int unsigned ch, int unsigned cv, int unsigned cw,
			int unsigned chh, int unsigned mg, int unsigned sp);
		drain();
		write_cfg(REG_CELLS_H, ch);
		write_cfg(REG_CELLS_V, cv);
		write_cfg(REG_CELL_W, cw);
		write_cfg(REG_CELL_H, chh);
		write_cfg(REG_MARGIN, mg);
		write_cfg(REG_SEP, sp);
	endtask

	// Random command mix biased toward adds and fails landing in the grid.
	task automatic random_cmd();
		int unsigned sel, gx, gy, px, py, rw, rh;
		logic [2:0] op;
		sel = $urandom_range(0, 99);
		gx = grid_sb.axis_len(grid_sb.cfg_cells_h) * grid_sb.nz(grid_sb.cfg_cw);
		gy = grid_sb.axis_len(grid_sb.cfg_cells_v) * grid_sb.nz(grid_sb.cfg_ch);
		px = (gx > 4096) ? $urandom_range(0, 4095) : $urandom_range(0, gx - 1);
		py = (gy > 4096) ? $urandom_range(0, 4095) : $urandom_range(0, gy - 1);
		rw = $urandom_range(0, 1024);
		rh = $urandom_range(0, 1024);
		if (sel < 3) op = OP_CLEAR;
		else if (sel < 7) op = OP_RENEW;
		else if (sel < 50) op = OP_ADD;
		else if (sel < 75) op = OP_PICK;
		else if (sel < 95) begin
			op = OP_FAIL;
			rw = $urandom_range(0, 2 * grid_sb.nz(grid_sb.cfg_cw));
			rh = $urandom_range(0, 2 * grid_sb.nz(grid_sb.cfg_ch));
			px = (px > rw / 2) ? px - rw / 2 : 0;
			py = (py > rh / 2) ? py - rh / 2 : 0;
		end else op = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 9) == 0) begin	// noise: full field range
			px = $urandom_range(0, 4095);
			py = $urandom_range(0, 4095);
			rw = $urandom_range(0, 2047);
			rh = $urandom_range(0, 2047);
		end
		send_cmd(op, px, py, rw, rh, $urandom_range(0, 65535), $urandom_range(0, 65535));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// Directed: reset config, every op, extremes and special cases.
		send_cmd(OP_PICK, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_PICK, 0, 0, 0, 0, 65535, 0);
		send_cmd(OP_RENEW, 0, 0, 0, 0, 65535, 65535);
		send_cmd(OP_ADD, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_ADD, 4095, 4095, 0, 0, 0, 0);
		send_cmd(OP_ADD, 100, 100, 0, 0, 0, 0);
		send_cmd(OP_FAIL, 150, 150, 20, 20, 0, 0);
		send_cmd(OP_FAIL, 4095, 4095, 2047, 2047, 0, 0);
		send_cmd(OP_ADD, 170, 170, 0, 0, 0, 0);	// failed cell returns to counting
		send_cmd(OP_PICK, 0, 0, 0, 0, 'h1234, 0);
		send_cmd(3'd5, 4095, 4095, 2047, 2047, 65535, 65535);
		send_cmd(3'd7, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		// Saturation at 255.
		for (int i = 0; i < 257; i++) send_cmd(OP_ADD, 90, 90, 0, 0, 0, 0);
		send_cmd(OP_PICK, 0, 0, 0, 0, 7, 0);

		// Pressure: sender holds until every result is in.
		drain();

		// Oversize grid, zero cell size, margin too large, large separation.
		setup(31, 31, 0, 0, 255, 255);
		send_cmd(OP_RENEW, 0, 0, 0, 0, 65535, 65535);
		send_cmd(OP_PICK, 0, 0, 0, 0, 65535, 0);
		send_cmd(OP_ADD, 4095, 0, 0, 0, 0, 0);

		setup(2, 2, 2047, 2047, 0, 0);
		send_cmd(OP_PICK, 0, 0, 0, 0, 3, 0);
		send_cmd(OP_RENEW, 0, 0, 0, 0, 65535, 0);
		send_cmd(OP_PICK, 0, 0, 0, 0, 0, 0);

		// Random phases over varied settings.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: setup(8, 6, 80, 80, 0, 0);
				1: setup(16, 16, 4, 4, 1, 1);
				2: setup(16, 16, 250, 250, 100, 10);
				3: setup(2, 2, 1024, 1024, 255, 255);
				default: setup($urandom_range(2, 16), $urandom_range(2, 16),
					$urandom_range(4, 300), $urandom_range(4, 300),
					$urandom_range(0, 40), $urandom_range(0, 60));
			endcase
			send_cmd(OP_RENEW, 0, 0, 0, 0, $urandom_range(0, 65535),
				$urandom_range(0, 65535));
			for (int n = 0; n < 120; n++) random_cmd();
		end

		drain();
		repeat (50) @(posedge clk);
		if (grid_sb.errors == 0 && grid_sb.pending_regions.size() == 0)
			$display("active_search_grid_core test passed");
		else
			$display("active_search_grid_core test failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/asg_pkg.sv
rtl/core/asg_div.sv
rtl/core/asg_mem.sv
rtl/core/active_search_grid_core.sv
verif/tb_active_search_grid_core.sv
